// ===== src/co2rfc_pkg.sv =====
// Shared types, codes and frame constants for the CO2 reply frame checker.
package co2rfc_pkg;

    localparam logic [2:0] OUT_OK           = 3'd0;
    localparam logic [2:0] OUT_PREHEAT      = 3'd1;
    localparam logic [2:0] OUT_SENSOR_ERR   = 3'd2;
    localparam logic [2:0] OUT_BAD_HEADER   = 3'd3;
    localparam logic [2:0] OUT_BAD_SUM      = 3'd4;
    localparam logic [2:0] OUT_ACK_MISMATCH = 3'd5;

    localparam logic [1:0] KIND_READING  = 2'd0;
    localparam logic [1:0] KIND_ZERO_ACK = 2'd1;
    localparam logic [1:0] KIND_BASE_ACK = 2'd2;

    localparam logic [2:0] LAST_READING = 3'd7;
    localparam logic [2:0] LAST_ACK     = 3'd3;
    localparam logic [2:0] POS_PPM_HI   = 3'd3;
    localparam logic [2:0] POS_PPM_LO   = 3'd4;
    localparam logic [2:0] POS_STATUS   = 3'd5;
    localparam logic [2:0] POS_EXTRA    = 3'd6;

    localparam logic [7:0] HDR_LEAD      = 8'h16;
    localparam logic [7:0] HDR_READ_CMD  = 8'h05;
    localparam logic [7:0] HDR_ACK_LEN   = 8'h01;
    localparam logic [7:0] HDR_READ_LEN  = 8'h01;
    localparam logic [7:0] HDR_ZERO_CMD  = 8'h03;
    localparam logic [7:0] HDR_BASE_CMD  = 8'h10;
    localparam logic [7:0] ACK_ZERO_SUM  = 8'hE6;
    localparam logic [7:0] ACK_BASE_SUM  = 8'hD9;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_beat;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [15:0] co2_ppm;
        logic [7:0]  status_byte;
        logic [7:0]  extra_byte;
    } t_result;

    function automatic logic [1:0] kind_of(input logic [1:0] sel);
        logic [1:0] k;
        k = KIND_READING;
        if (sel == KIND_ZERO_ACK || sel == KIND_BASE_ACK) begin
            k = sel;
        end
        return k;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [1:0] kind, input logic [1:0] pos);
        logic [7:0] b;
        b = HDR_LEAD;
        unique case (pos)
            2'd0: b = HDR_LEAD;
            2'd1: b = (kind == KIND_READING) ? HDR_READ_CMD : HDR_ACK_LEN;
            2'd2: begin
                if (kind == KIND_ZERO_ACK) begin
                    b = HDR_ZERO_CMD;
                end else if (kind == KIND_BASE_ACK) begin
                    b = HDR_BASE_CMD;
                end else begin
                    b = HDR_READ_LEN;
                end
            end
            default: b = HDR_LEAD;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ack_last(input logic [1:0] kind);
        return (kind == KIND_BASE_ACK) ? ACK_BASE_SUM : ACK_ZERO_SUM;
    endfunction

endpackage

// ===== src/co2rfc_byte_if.sv =====
// Handshake channel for received reply bytes.
interface co2rfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== src/co2rfc_result_if.sv =====
// Handshake channel for frame check results.
interface co2rfc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic [15:0] co2_ppm;
    logic [7:0]  status_byte;
    logic [7:0]  extra_byte;

    modport source (output valid, output outcome, output co2_ppm, output status_byte,
                    output extra_byte, input ready);
    modport sink (input valid, input outcome, input co2_ppm, input status_byte,
                  input extra_byte, output ready);
endinterface

// ===== src/co2rfc_in_stage.sv =====
// Input register stage holding one accepted byte beat.
module co2rfc_in_stage
    import co2rfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_beat i_beat,
    input  logic  i_advance,
    output logic  o_ready,
    output logic  o_valid,
    output t_beat o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

// ===== src/co2rfc_frame_core.sv =====
// Frame tracking state, checksum, header check and outcome decode.
module co2rfc_frame_core
    import co2rfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_beat      i_beat,
    input  logic [1:0] i_expected_reply,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [2:0]  r_pos, n_pos;
    logic        r_idle, n_idle;
    logic [7:0]  r_sum, n_sum;
    logic        r_hdr, n_hdr;
    logic [15:0] r_ppm, n_ppm;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_extra, n_extra;

    logic [1:0]  w_kind;
    logic [2:0]  w_last;
    logic [7:0]  w_neg_sum;
    logic [7:0]  w_b;

    assign w_kind = kind_of(i_expected_reply);
    assign w_last = (w_kind == KIND_READING) ? LAST_READING : LAST_ACK;
    assign w_b    = i_beat.rx_byte;

    always_comb begin
        n_pos       = r_pos;
        n_idle      = r_idle;
        n_sum       = r_sum;
        n_hdr       = r_hdr;
        n_ppm       = r_ppm;
        n_status    = r_status;
        n_extra     = r_extra;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_neg_sum   = 8'd0;
        if (i_step && (i_beat.frame_start || !r_idle)) begin
            if (i_beat.frame_start) begin
                n_pos    = 3'd0;
                n_idle   = 1'b0;
                n_sum    = 8'd0;
                n_hdr    = 1'b1;
                n_ppm    = 16'd0;
                n_status = 8'd0;
                n_extra  = 8'd0;
            end
            w_neg_sum = 8'(8'd0 - n_sum);
            if (n_pos >= w_last) begin
                o_res_valid = 1'b1;
                if (w_kind == KIND_READING) begin
                    if (!n_hdr) begin
                        o_res.outcome = OUT_BAD_HEADER;
                    end else if (w_b != w_neg_sum) begin
                        o_res.outcome = OUT_BAD_SUM;
                    end else if (n_status == 8'd0) begin
                        o_res.outcome = OUT_OK;
                    end else if (n_status[0]) begin
                        o_res.outcome = OUT_PREHEAT;
                    end else begin
                        o_res.outcome = OUT_SENSOR_ERR;
                    end
                    o_res.co2_ppm     = n_ppm;
                    o_res.status_byte = n_status;
                    o_res.extra_byte  = n_extra;
                end else begin
                    o_res.outcome = (n_hdr && w_b == ack_last(w_kind)) ? OUT_OK
                                                                       : OUT_ACK_MISMATCH;
                end
                n_idle = 1'b1;
                n_pos  = 3'd0;
            end else begin
                n_sum = 8'(n_sum + w_b);
                if (n_pos < POS_PPM_HI) begin
                    if (w_b != hdr_byte(w_kind, n_pos[1:0])) begin
                        n_hdr = 1'b0;
                    end
                end else if (n_pos == POS_PPM_HI) begin
                    n_ppm[15:8] = w_b;
                end else if (n_pos == POS_PPM_LO) begin
                    n_ppm[7:0] = w_b;
                end else if (n_pos == POS_STATUS) begin
                    n_status = w_b;
                end else if (n_pos == POS_EXTRA) begin
                    n_extra = w_b;
                end
                n_pos = 3'(n_pos + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 3'd0;
            r_idle   <= 1'b1;
            r_sum    <= 8'd0;
            r_hdr    <= 1'b1;
            r_ppm    <= 16'd0;
            r_status <= 8'd0;
            r_extra  <= 8'd0;
        end else begin
            r_pos    <= n_pos;
            r_idle   <= n_idle;
            r_sum    <= n_sum;
            r_hdr    <= n_hdr;
            r_ppm    <= n_ppm;
            r_status <= n_status;
            r_extra  <= n_extra;
        end
    end

endmodule

// ===== src/co2rfc_out_stage.sv =====
// Result register driving the output channel.
module co2rfc_out_stage
    import co2rfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== src/co2_sensor_reply_frame_checker_unit.sv =====
// Top level of the CO2 sensor reply frame checker.
// Takes one reply byte per cycle while input ready is high. A byte goes into an input
// register and is checked against the running frame state as it leaves that register;
// a frame's result is loaded into the output register as its last byte leaves the input
// register. A result that waits to be taken holds the output register; one more byte can
// sit in the input register meanwhile, and input ready drops only while both are full.
// The expected reply register is written through i_cfg_wr_en/i_cfg_wr_data; the user must
// write it only while no byte or result is in flight, the block itself does not enforce it.
module co2_sensor_reply_frame_checker_unit
    import co2rfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    co2rfc_byte_if.sink     i_byte,
    co2rfc_result_if.source o_result
);

    logic [1:0] r_expected_reply;
    logic       w_advance;
    logic       w_beat_valid;
    t_beat      w_in_beat;
    t_beat      w_beat;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_reply <= KIND_READING;
        end else if (i_cfg_wr_en) begin
            r_expected_reply <= i_cfg_wr_data;
        end
    end

    assign w_in_beat.rx_byte     = i_byte.rx_byte;
    assign w_in_beat.frame_start = i_byte.frame_start;

    co2rfc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_byte.valid),
        .i_beat    (w_in_beat),
        .i_advance (w_advance),
        .o_ready   (i_byte.ready),
        .o_valid   (w_beat_valid),
        .o_beat    (w_beat)
    );

    co2rfc_frame_core u_frame_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_beat_valid && w_advance),
        .i_beat           (w_beat),
        .i_expected_reply (r_expected_reply),
        .o_res_valid      (w_res_valid),
        .o_res            (w_res)
    );

    co2rfc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_beat_valid),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_ready     (o_result.ready),
        .o_advance   (w_advance),
        .o_valid     (o_result.valid),
        .o_res       (w_out)
    );

    assign o_result.outcome     = w_out.outcome;
    assign o_result.co2_ppm     = w_out.co2_ppm;
    assign o_result.status_byte = w_out.status_byte;
    assign o_result.extra_byte  = w_out.extra_byte;

    a_result_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(w_beat_valid))
        else $error("result appeared without a byte beat in the input register");

    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.outcome <= OUT_ACK_MISMATCH)
        else $error("outcome code out of range");

    a_ack_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.outcome == OUT_ACK_MISMATCH) |->
        (o_result.co2_ppm == 16'd0 && o_result.status_byte == 8'd0
         && o_result.extra_byte == 8'd0))
        else $error("ack result carries reading fields");

    a_stall_holds_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat_valid && !w_advance) |=> (w_beat_valid && $stable(w_beat)))
        else $error("stalled byte beat lost");

endmodule
